@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL of the Huffman block.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HTB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define HTB_ASSERT(label, prop, msg)
`define HTB_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/htb_pkg.sv @@
// Package of the Huffman tree build and decode block: transaction types, codes, defaults.
// No dependencies.
`default_nettype none
package htb_pkg;

    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 24;
    localparam int BYTE_BITS       = 8;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  symbol;
        logic [23:0] weight;
        logic [7:0]  data_byte;
        logic [3:0]  bit_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  symbol_out;
        logic [31:0] root_weight;
        logic        last;
    } rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/huffman_tree_build_and_decode.sv @@
// Huffman tree builder and decoder, top level.
// Depends on htb_pkg and assert_macros.svh.
//
// Load transactions append (symbol, weight) entries; a build transaction turns them into a tree
// held in a node memory and returns the root weight, or an error when no entry was loaded; a
// decode transaction walks the tree one bit per step, MSB first, and returns one transaction per
// leaf reached, the last one marked. One item is worked on at a time. A build first seeds the
// memories with one read of the entry memory and one write to the node and work memories per
// entry. Each merge then reads the front pair of the work list, writes the new node and shifts
// the entries behind the pair down, as the sorted insertion is one read and one write of the work
// memory per entry, and one more of each when the new node lands before one of them. Last the
// root is read and the response is given. A decode reads the current node and then its child
// from the node memory, which has a registered read, and hands out the last symbol at the end.
`default_nettype none
`include "assert_macros.svh"
module huffman_tree_build_and_decode #(
    parameter int MAX_SYMBOLS = htb_pkg::MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = htb_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire htb_pkg::req_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output htb_pkg::rsp_t     rsp
);

    localparam int NODE_SLOTS = 2 * MAX_SYMBOLS - 1;
    localparam int NIW        = $clog2(NODE_SLOTS);
    localparam int NCW        = $clog2(NODE_SLOTS + 1);
    localparam int EIW        = $clog2(MAX_SYMBOLS);
    localparam int CW         = $clog2(MAX_SYMBOLS + 1);

    typedef struct packed {
        logic [7:0]             symbol;
        logic [WEIGHT_BITS-1:0] weight;
    } entry_t;

    typedef struct packed {
        logic           leaf;
        logic [7:0]     symbol;
        logic [NIW-1:0] left;
        logic [NIW-1:0] right;
    } node_t;

    typedef struct packed {
        logic [31:0]    weight;
        logic [NIW-1:0] node;
    } work_t;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_INIT_RD, S_INIT_WR, S_M_RDA, S_M_RDB, S_M_NODE,
        S_SH_RD, S_SH_DO, S_ROOT_RD, S_ROOT_DO, S_D_RD, S_D_CHK1, S_D_CHK2, S_D_FLUSH
    } state_t;

    // Memories.
    entry_t ent_mem [MAX_SYMBOLS];
    node_t  node_mem [NODE_SLOTS];
    work_t  work_mem [MAX_SYMBOLS];

    entry_t         ent_rd;
    node_t          node_rd;
    work_t          work_rd;
    logic           ent_we, ent_re, node_we, node_re, work_we, work_re;
    logic [EIW-1:0] ent_waddr, ent_raddr, work_waddr, work_raddr;
    logic [NIW-1:0] node_waddr, node_raddr;
    entry_t         ent_wdata;
    node_t          node_wdata;
    work_t          work_wdata;

    // Control and data registers.
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  m_reg, m_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  s_reg, s_next;
    logic [CW-1:0]  d_reg, d_next;
    logic           ins_reg, ins_next;
    logic [NCW-1:0] ncount_reg, ncount_next;
    work_t          a_reg, a_next;
    logic [31:0]    mw_reg, mw_next;
    logic [NIW-1:0] mnode_reg, mnode_next;
    logic [NIW-1:0] root_reg, root_next;
    logic [NIW-1:0] walk_reg, walk_next;
    logic [NIW-1:0] child_reg, child_next;
    logic           tree_ready_reg, tree_ready_next;
    logic [7:0]     data_reg, data_next;
    logic [3:0]     left_reg, left_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [7:0]     pend_sym_reg, pend_sym_next;
    logic           rsp_valid_reg, rsp_valid_next;
    htb_pkg::rsp_t  rsp_reg, rsp_next;

    logic           can_push;
    logic           found, found_ok;
    logic [7:0]     found_sym;
    logic           bit_done;
    logic [31:0]    ld_weight32;
    logic [NIW-1:0] child_sel;

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign can_push    = !rsp_valid_reg || !rsp_stall;
    assign ld_weight32 = 32'(req.weight);
    assign child_sel   = data_reg[7] ? node_rd.right : node_rd.left;

    // Entry memory.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rd <= ent_mem[ent_raddr];
        end
    end

    // Node memory.
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rd <= node_mem[node_raddr];
        end
    end

    // Work list memory; merges copy it in place, always reading ahead of the write pointer.
    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (work_re)
        begin
            work_rd <= work_mem[work_raddr];
        end
    end

    // Sequencer for load, build and decode.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        m_next          = m_reg;
        i_next          = i_reg;
        s_next          = s_reg;
        d_next          = d_reg;
        ins_next        = ins_reg;
        ncount_next     = ncount_reg;
        a_next          = a_reg;
        mw_next         = mw_reg;
        mnode_next      = mnode_reg;
        root_next       = root_reg;
        walk_next       = walk_reg;
        child_next      = child_reg;
        tree_ready_next = tree_ready_reg;
        data_next       = data_reg;
        left_next       = left_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;

        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_waddr  = cnt_reg[EIW-1:0];
        ent_raddr  = i_reg[EIW-1:0];
        ent_wdata  = '{symbol: req.symbol, weight: ld_weight32[WEIGHT_BITS-1:0]};
        node_we    = 1'b0;
        node_re    = 1'b0;
        node_waddr = ncount_reg[NIW-1:0];
        node_raddr = walk_reg;
        node_wdata = '{leaf: 1'b1, symbol: ent_rd.symbol, left: '0, right: '0};
        work_we    = 1'b0;
        work_re    = 1'b0;
        work_waddr = d_reg[EIW-1:0];
        work_raddr = s_reg[EIW-1:0];
        work_wdata = work_rd;

        found     = 1'b0;
        found_sym = node_rd.symbol;
        bit_done  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.opcode)
                        htb_pkg::OP_LOAD:
                        begin
                            if (cnt_reg < CW'(MAX_SYMBOLS))
                            begin
                                ent_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        htb_pkg::OP_BUILD:
                        begin
                            if (cnt_reg == '0)
                            begin
                                tree_ready_next = 1'b0;
                                state_next      = S_ERR;
                            end
                            else
                            begin
                                i_next     = '0;
                                m_next     = cnt_reg;
                                state_next = S_INIT_RD;
                            end
                        end
                        htb_pkg::OP_DECODE:
                        begin
                            if (tree_ready_reg && req.bit_count != 4'd0)
                            begin
                                data_next  = req.data_byte;
                                left_next  = (req.bit_count > 4'(htb_pkg::BYTE_BITS)) ?
                                             4'(htb_pkg::BYTE_BITS) : req.bit_count;
                                state_next = S_D_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ERR:
            begin
                if (can_push)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{kind: htb_pkg::KIND_ERROR, symbol_out: '0,
                                       root_weight: '0, last: 1'b1};
                    state_next     = S_IDLE;
                end
            end
            S_INIT_RD:
            begin
                ent_re     = 1'b1;
                state_next = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                // Seed one leaf node and one work list entry.
                node_we    = 1'b1;
                node_waddr = NIW'(i_reg);
                work_we    = 1'b1;
                work_waddr = i_reg[EIW-1:0];
                work_wdata = '{weight: 32'(ent_rd.weight), node: NIW'(i_reg)};
                i_next     = i_reg + 1'b1;
                if (i_reg + 1'b1 == m_reg)
                begin
                    ncount_next = NCW'(m_reg);
                    state_next  = (m_reg > CW'(1)) ? S_M_RDA : S_ROOT_RD;
                end
                else
                begin
                    state_next = S_INIT_RD;
                end
            end
            S_M_RDA:
            begin
                work_re    = 1'b1;
                work_raddr = '0;
                state_next = S_M_RDB;
            end
            S_M_RDB:
            begin
                a_next     = work_rd;
                work_re    = 1'b1;
                work_raddr = EIW'(1);
                state_next = S_M_NODE;
            end
            S_M_NODE:
            begin
                // Merge the two front entries into a new inner node.
                node_we     = 1'b1;
                node_wdata  = '{leaf: 1'b0, symbol: '0, left: a_reg.node, right: work_rd.node};
                mw_next     = a_reg.weight + work_rd.weight;
                mnode_next  = ncount_reg[NIW-1:0];
                ncount_next = ncount_reg + 1'b1;
                s_next      = CW'(2);
                d_next      = '0;
                ins_next    = 1'b0;
                state_next  = S_SH_RD;
            end
            S_SH_RD:
            begin
                if (s_reg < m_reg)
                begin
                    work_re    = 1'b1;
                    state_next = S_SH_DO;
                end
                else
                begin
                    if (!ins_reg)
                    begin
                        work_we    = 1'b1;
                        work_wdata = '{weight: mw_reg, node: mnode_reg};
                    end
                    m_next     = m_reg - 1'b1;
                    state_next = (m_reg - 1'b1 > CW'(1)) ? S_M_RDA : S_ROOT_RD;
                end
            end
            S_SH_DO:
            begin
                // Shift down by two, or one once the merged node sits before the first heavier.
                work_we = 1'b1;
                d_next  = d_reg + 1'b1;
                if (ins_reg || work_rd.weight <= mw_reg)
                begin
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    work_wdata = '{weight: mw_reg, node: mnode_reg};
                    ins_next   = 1'b1;
                end
                state_next = S_SH_RD;
            end
            S_ROOT_RD:
            begin
                work_re    = 1'b1;
                work_raddr = '0;
                state_next = S_ROOT_DO;
            end
            S_ROOT_DO:
            begin
                if (can_push)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = '{kind: htb_pkg::KIND_DONE, symbol_out: '0,
                                        root_weight: work_rd.weight, last: 1'b1};
                    root_next       = work_rd.node;
                    walk_next       = work_rd.node;
                    tree_ready_next = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_D_RD:
            begin
                node_re    = 1'b1;
                state_next = S_D_CHK1;
            end
            S_D_CHK1:
            begin
                if (node_rd.leaf)
                begin
                    found = 1'b1;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = child_sel;
                    child_next = child_sel;
                    state_next = S_D_CHK2;
                end
            end
            S_D_CHK2:
            begin
                if (node_rd.leaf)
                begin
                    found = 1'b1;
                end
                else
                begin
                    walk_next = child_reg;
                    bit_done  = 1'b1;
                end
            end
            S_D_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = '{kind: htb_pkg::KIND_SYMBOL, symbol_out: pend_sym_reg,
                                        root_weight: '0, last: 1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A leaf was reached: hand the held symbol on and hold the new one, so the last is known.
        found_ok = found && (!pend_valid_reg || can_push);
        if (found_ok)
        begin
            if (pend_valid_reg)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{kind: htb_pkg::KIND_SYMBOL, symbol_out: pend_sym_reg,
                                   root_weight: '0, last: 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = found_sym;
            walk_next       = root_reg;
            bit_done        = 1'b1;
        end

        if (bit_done)
        begin
            data_next  = {data_reg[6:0], 1'b0};
            left_next  = left_reg - 4'd1;
            state_next = (left_reg == 4'd1) ? S_D_FLUSH : S_D_RD;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ncount_reg     <= '0;
            root_reg       <= '0;
            walk_reg       <= '0;
            tree_ready_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            m_reg          <= '0;
            i_reg          <= '0;
            s_reg          <= '0;
            d_reg          <= '0;
            ins_reg        <= 1'b0;
            left_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ncount_reg     <= ncount_next;
            root_reg       <= root_next;
            walk_reg       <= walk_next;
            tree_ready_reg <= tree_ready_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            m_reg          <= m_next;
            i_reg          <= i_next;
            s_reg          <= s_next;
            d_reg          <= d_next;
            ins_reg        <= ins_next;
            left_reg       <= left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        mw_reg       <= mw_next;
        mnode_reg    <= mnode_next;
        child_reg    <= child_next;
        data_reg     <= data_next;
        pend_sym_reg <= pend_sym_next;
        rsp_reg      <= rsp_next;
    end

    // Checks.
    `HTB_ASSERT_IMP(a_copy_ahead, state_reg == S_SH_DO, s_reg > d_reg, "work list copy overran")
    `HTB_ASSERT_IMP(a_merge_size, state_reg == S_M_RDA, m_reg > CW'(1), "merge with one entry")
    `HTB_ASSERT_IMP(a_walk_range, tree_ready_reg && state_reg == S_D_RD,
        NCW'(walk_reg) < ncount_reg, "walk left the built tree")
    `HTB_ASSERT(a_no_overwrite, (rsp_valid_reg && rsp_stall) |=> rsp_valid_reg,
        "pending transaction dropped")

endmodule
`default_nettype wire
